// File: src/tbe_pkg.sv
package tbe_pkg;

  localparam int unsigned ROW_W = 3;

  // pixel masks for the two modes
  localparam logic [3:0] PIX_MASK_2BPP = 4'h3;
  localparam logic [3:0] PIX_MASK_4BPP = 4'hF;

  // byte sequencer phases in the back end
  localparam int unsigned PHASE_W       = 5;
  localparam int unsigned DUMP_BYTES    = 16;
  localparam logic [PHASE_W-1:0] PH_PLANE0     = 5'd0;
  localparam logic [PHASE_W-1:0] PH_PLANE1     = 5'd1;
  localparam logic [PHASE_W-1:0] PH_DUMP_FIRST = 5'd2;
  localparam logic [PHASE_W-1:0] PH_DUMP_LAST  = PH_DUMP_FIRST + PHASE_W'(DUMP_BYTES - 1);

  localparam logic [1:0] PLANE_0 = 2'd0;
  localparam logic [1:0] PLANE_1 = 2'd1;
  localparam logic [1:0] PLANE_2 = 2'd2;
  localparam logic [1:0] PLANE_3 = 2'd3;

  // one classified row, front to back
  typedef struct packed {
    logic [7:0]       plane0;
    logic [7:0]       plane1;
    logic [7:0]       plane2;
    logic [7:0]       plane3;
    logic [ROW_W-1:0] row;
    logic             dump;      // row 7 in 4bpp: stored planes follow
    logic             tile_end;  // row 7 in either mode
  } tbe_item_t;

  // bit p of each pixel, leftmost pixel to bit 7
  function automatic logic [7:0] plane_of(input logic [31:0] pixels,
                                          input logic [1:0]  plane,
                                          input logic [3:0]  mask);
    logic [7:0] b;
    logic [3:0] pix;
    b   = '0;
    pix = '0;
    for (int c = 0; c < 8; c++) begin
      pix      = pixels[(7 - c) * 4 +: 4] & mask;
      b[7 - c] = pix[plane];
    end
    return b;
  endfunction

endpackage

// File: src/tbe_front.sv
module tbe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_four_plane_mode,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_pixel_row,
  input  logic                q_full,
  output logic                q_push,
  output tbe_pkg::tbe_item_t  q_item
);

  logic                      mode_r;
  logic [tbe_pkg::ROW_W-1:0] row_r;
  logic [tbe_pkg::ROW_W-1:0] row_nxt;
  logic [3:0]                mask;
  logic                      accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept;
  assign mask      = mode_r ? tbe_pkg::PIX_MASK_4BPP : tbe_pkg::PIX_MASK_2BPP;
  assign row_nxt   = row_r + 1'b1;

  always_comb begin
    q_item.plane0   = tbe_pkg::plane_of(in_pixel_row, tbe_pkg::PLANE_0, mask);
    q_item.plane1   = tbe_pkg::plane_of(in_pixel_row, tbe_pkg::PLANE_1, mask);
    // upper planes are always stored, full pixel width
    q_item.plane2   = tbe_pkg::plane_of(in_pixel_row, tbe_pkg::PLANE_2,
                                        tbe_pkg::PIX_MASK_4BPP);
    q_item.plane3   = tbe_pkg::plane_of(in_pixel_row, tbe_pkg::PLANE_3,
                                        tbe_pkg::PIX_MASK_4BPP);
    q_item.row      = row_r;
    q_item.tile_end = &row_r;
    q_item.dump     = mode_r && (&row_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      row_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_four_plane_mode;
      end
      if (accept) begin
        row_r <= row_nxt;
      end
    end
  end

endmodule

// File: src/tbe_queue.sv
module tbe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tbe_pkg::tbe_item_t  item_in,
  output logic                full,
  input  logic                pop,
  output tbe_pkg::tbe_item_t  item_out,
  output logic                empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tbe_pkg::tbe_item_t slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign item_out = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: src/tbe_back.sv
module tbe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  tbe_pkg::tbe_item_t  q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_plane_byte,
  output logic                out_last_of_item,
  output logic                out_last_of_tile
);

  tbe_pkg::tbe_item_t          item_r;
  logic                        busy_r;
  logic [tbe_pkg::PHASE_W-1:0] phase_r;
  logic [15:0]                 store_r [8];  // plane 2 in 15:8, plane 3 in 7:0

  logic                        out_valid_r;
  logic [7:0]                  byte_r;
  logic                        last_item_r;
  logic                        last_tile_r;

  logic                        load_ok, step, finish;
  logic [tbe_pkg::PHASE_W-1:0] last_phase;
  logic [tbe_pkg::PHASE_W-1:0] dump_off;
  logic [3:0]                  dump_idx;
  logic [15:0]                 entry;
  logic [7:0]                  byte_nxt;
  logic                        last_item_nxt, last_tile_nxt;

  assign load_ok    = !out_valid_r || out_ready;
  assign step       = busy_r && load_ok;
  assign last_phase = item_r.dump ? tbe_pkg::PH_DUMP_LAST : tbe_pkg::PH_PLANE1;
  assign finish     = step && (phase_r == last_phase);
  assign q_pop      = !q_empty && (!busy_r || finish);

  assign dump_off = phase_r - tbe_pkg::PH_DUMP_FIRST;
  assign dump_idx = dump_off[3:0];
  assign entry    = store_r[dump_idx[3:1]];

  always_comb begin
    unique case (phase_r)
      tbe_pkg::PH_PLANE0: begin
        byte_nxt      = item_r.plane0;
        last_item_nxt = 1'b0;
        last_tile_nxt = 1'b0;
      end
      tbe_pkg::PH_PLANE1: begin
        byte_nxt      = item_r.plane1;
        last_item_nxt = !item_r.dump;
        last_tile_nxt = item_r.tile_end && !item_r.dump;
      end
      default: begin
        byte_nxt      = dump_idx[0] ? entry[7:0] : entry[15:8];
        last_item_nxt = &dump_idx;
        last_tile_nxt = &dump_idx;
      end
    endcase
  end

  // store written as each row leaves the queue, so a dump sees rows 0..7
  always_ff @(posedge clk) begin
    if (q_pop) begin
      store_r[q_item.row] <= {q_item.plane2, q_item.plane3};
      item_r              <= q_item;
    end
    if (step) begin
      byte_r      <= byte_nxt;
      last_item_r <= last_item_nxt;
      last_tile_r <= last_tile_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r  <= 1'b1;
        phase_r <= tbe_pkg::PH_PLANE0;
      end else if (finish) begin
        busy_r  <= 1'b0;
      end else if (step) begin
        phase_r <= phase_r + 1'b1;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_plane_byte   = byte_r;
  assign out_last_of_item = last_item_r;
  assign out_last_of_tile = last_tile_r;

endmodule

// File: src/tile_bitplane_encoder.sv
// Tile bitplane encoder: 8x8 tiles of 4-bit palette indices in, planar
// tile bytes out.
//
// Input channel (in_*): one transfer per tile row, eight pixels, leftmost
// in bits 31:28. Output channel (out_*): one transfer per plane byte,
// leftmost pixel in bit 7, with last_of_item / last_of_tile flags.
// Config channel (cfg_*): four_plane_mode, written while idle; cfg_ready
// is always high. Takes effect from the next row.
//
// Each row gives planes 0 and 1 right away. In 4bpp mode row 7 also
// gives the sixteen stored plane 2/3 bytes, so a tile is 32 bytes.
// A row's first byte passes the queue, item_r and byte_r in turn. The
// back end sequencer emits one byte per cycle while out_ready is high,
// so a row costs 2 bytes in 2bpp mode and on average 4 bytes in 4bpp
// mode (18 for row 7). The front classifies a row per cycle into a
// QUEUE_DEPTH entry queue; in_ready drops only when that queue is full.
//
// Reset: row counter to 0, mode to 4bpp, queue and output emptied.
// Receiver stall: the output register holds its byte; the back end stops,
// the queue fills, then in_ready goes low. Nothing is dropped.
module tile_bitplane_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_four_plane_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_pixel_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_plane_byte,
  output logic        out_last_of_item,
  output logic        out_last_of_tile
);

  tbe_pkg::tbe_item_t push_item, pop_item;
  logic               q_push, q_pop, q_full, q_empty;

  // front: register, row counter, plane extraction
  tbe_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_four_plane_mode (cfg_four_plane_mode),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pixel_row        (in_pixel_row),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_item              (push_item)
  );

  // decouples row intake from byte output
  tbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .item_in  (push_item),
    .full     (q_full),
    .pop      (q_pop),
    .item_out (pop_item),
    .empty    (q_empty)
  );

  // back: row store, byte sequencer, output register
  tbe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_item           (pop_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_plane_byte   (out_plane_byte),
    .out_last_of_item (out_last_of_item),
    .out_last_of_tile (out_last_of_tile)
  );

endmodule
